@@ rtl/tlb_lru_page_translate_macros.svh @@
`ifndef TLB_LRU_PAGE_TRANSLATE_MACROS_SVH
`define TLB_LRU_PAGE_TRANSLATE_MACROS_SVH

// Checks that an implication holds on every rising edge outside reset.
`define TLBL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition holds in the cycle after the antecedent.
`define TLBL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Checks a condition that holds in every cycle outside reset.
`define TLBL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

@@ rtl/tlbl_pkg.sv @@
`timescale 1ns / 1ps

package tlbl_pkg;

	localparam int TLB_ENTRIES_DEF = 16;
	localparam int PAGE_COUNT_DEF  = 256;
	localparam int OFFSET_BITS_DEF = 8;

	localparam int VA_W    = 16;
	localparam int PA_W    = 16;
	localparam int COUNT_W = 16;

	// Update command broadcast to every TLB cell during the lookup cycle.
	typedef struct packed {
		logic update;
		logic shift_all;
	} cell_ctl_t;

endpackage

@@ rtl/tlbl_ram.sv @@
`timescale 1ns / 1ps

module tlbl_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/tlbl_cell.sv @@
`timescale 1ns / 1ps

module tlbl_cell import tlbl_pkg::*; #(
	parameter int TAG_W   = 8,
	parameter int FRAME_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic [TAG_W-1:0]   lookup_tag,
	input  logic               prev_valid,
	input  logic [TAG_W-1:0]   prev_tag,
	input  logic [FRAME_W-1:0] prev_frame,
	input  logic               hit_below_in,
	output logic               valid,
	output logic [TAG_W-1:0]   tag,
	output logic [FRAME_W-1:0] frame,
	output logic               match,
	output logic               hit_below_out
);

	logic               valid_q;
	logic [TAG_W-1:0]   tag_q;
	logic [FRAME_W-1:0] frame_q;
	logic               shift;

	assign match         = valid_q && (tag_q == lookup_tag);
	assign hit_below_out = hit_below_in | match;

	// On a hit only the cells from the head down to the hit cell move; an
	// insertion moves the whole row and drops the tail entry.
	assign shift = ctl.update & (ctl.shift_all | hit_below_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q   <= prev_tag;
			frame_q <= prev_frame;
		end
	end

	assign valid = valid_q;
	assign tag   = tag_q;
	assign frame = frame_q;

endmodule

@@ rtl/tlb_lru_page_translate.sv @@
`timescale 1ns / 1ps
`include "tlb_lru_page_translate_macros.svh"

// Translates a virtual address through a fully associative TLB kept as a
// row of cells in recency order (head is the most recent entry), backed by a
// page table in a single-port-read RAM that also holds each page's present
// bit. After reset the block clears the page table, one entry a cycle, with
// busy high until every entry is cleared. An item is taken when start is
// high and busy is low; its page-table read is issued as it is taken, and the
// lookup state then does the TLB compare, the TLB update and the page-table
// write. done pulses for one cycle with the result in the cycle after the
// lookup state, which is also the first cycle a new item can be taken. The
// receiver cannot stall; results must be captured while done is high.
// hit_total and fault_total hold their value until the next item completes.
// PAGE_COUNT must be a power of two; page numbers beyond it wrap.
module tlb_lru_page_translate import tlbl_pkg::*; #(
	parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
	parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VA_W-1:0]    virtual_address,
	output logic               done,
	output logic [PA_W-1:0]    physical_address,
	output logic               tlb_hit,
	output logic               page_fault,
	output logic [COUNT_W-1:0] hit_total,
	output logic [COUNT_W-1:0] fault_total
);

	localparam int PAGE_BITS = $clog2(PAGE_COUNT);
	localparam int ENTRY_W   = PAGE_BITS + 1;
	localparam int FULL_W    = PAGE_BITS + OFFSET_BITS;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;

	logic [1:0]             state_q;
	logic [PAGE_BITS-1:0]   clr_q;
	logic [VA_W-1:0]        va_q;
	logic [PAGE_BITS:0]     next_free_q;
	logic [COUNT_W-1:0]     hit_cnt_q;
	logic [COUNT_W-1:0]     fault_cnt_q;
	logic                   done_q;
	logic [PA_W-1:0]        phys_q;
	logic                   hit_q;
	logic                   fault_q;

	logic                   accept;
	logic [VA_W-1:0]        page_raw_in;
	logic [VA_W-1:0]        page_raw_q;
	logic [PAGE_BITS-1:0]   page_in;
	logic [PAGE_BITS-1:0]   page_q;
	logic [OFFSET_BITS-1:0] offset_q;

	logic                   ram_we;
	logic [PAGE_BITS-1:0]   ram_waddr;
	logic [ENTRY_W-1:0]     ram_wdata;
	logic [ENTRY_W-1:0]     ram_rdata;
	logic                   ram_present;
	logic [PAGE_BITS-1:0]   ram_frame;

	cell_ctl_t              ctl;
	logic                   cell_valid  [TLB_ENTRIES];
	logic [PAGE_BITS-1:0]   cell_tag    [TLB_ENTRIES];
	logic [PAGE_BITS-1:0]   cell_frame  [TLB_ENTRIES];
	logic                   in_valid    [TLB_ENTRIES];
	logic [PAGE_BITS-1:0]   in_tag      [TLB_ENTRIES];
	logic [PAGE_BITS-1:0]   in_frame    [TLB_ENTRIES];
	logic [TLB_ENTRIES:0]   hit_below;
	logic [TLB_ENTRIES-1:0] match_vec;
	logic [TLB_ENTRIES-1:0] valid_vec;
	logic [TLB_ENTRIES:0]   valid_plus;

	logic                   lookup;
	logic                   hit;
	logic [PAGE_BITS-1:0]   hit_frame;
	logic                   frames_gone;
	logic [PAGE_BITS-1:0]   alloc_frame;
	logic [PAGE_BITS-1:0]   res_frame;
	logic [FULL_W+PA_W-1:0] phys_ext;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign lookup = (state_q == ST_LOOKUP);

	assign page_raw_in = virtual_address >> OFFSET_BITS;
	assign page_in     = page_raw_in[PAGE_BITS-1:0];
	assign page_raw_q  = va_q >> OFFSET_BITS;
	assign page_q      = page_raw_q[PAGE_BITS-1:0];
	assign offset_q    = va_q[OFFSET_BITS-1:0];

	assign ram_present = ram_rdata[PAGE_BITS];
	assign ram_frame   = ram_rdata[PAGE_BITS-1:0];

	assign frames_gone = (next_free_q == (PAGE_BITS + 1)'(PAGE_COUNT));
	assign alloc_frame = frames_gone ? PAGE_BITS'(PAGE_COUNT - 1)
	                                 : next_free_q[PAGE_BITS-1:0];

	// The table is written by the clearing pass, or on a page fault.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (lookup && !hit && !ram_present) begin
			ram_we    = 1'b1;
			ram_waddr = page_q;
			ram_wdata = {1'b1, alloc_frame};
		end
	end

	tlbl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PAGE_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (page_in),
		.rdata (ram_rdata)
	);

	assign hit_below[TLB_ENTRIES] = 1'b0;
	assign hit                    = hit_below[0];

	assign ctl.update    = lookup && (hit || ram_present);
	assign ctl.shift_all = !hit;

	genvar gi;
	generate
		for (gi = 0; gi < TLB_ENTRIES; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign in_valid[gi] = 1'b1;
				assign in_tag[gi]   = page_q;
				assign in_frame[gi] = hit ? hit_frame : ram_frame;
			end else begin : g_body
				assign in_valid[gi] = cell_valid[gi-1];
				assign in_tag[gi]   = cell_tag[gi-1];
				assign in_frame[gi] = cell_frame[gi-1];
			end

			tlbl_cell #(
				.TAG_W   (PAGE_BITS),
				.FRAME_W (PAGE_BITS)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.ctl           (ctl),
				.lookup_tag    (page_q),
				.prev_valid    (in_valid[gi]),
				.prev_tag      (in_tag[gi]),
				.prev_frame    (in_frame[gi]),
				.hit_below_in  (hit_below[gi+1]),
				.valid         (cell_valid[gi]),
				.tag           (cell_tag[gi]),
				.frame         (cell_frame[gi]),
				.match         (match_vec[gi]),
				.hit_below_out (hit_below[gi])
			);

			assign valid_vec[gi] = cell_valid[gi];
		end
	endgenerate

	// Tags are unique among valid cells, so at most one term is nonzero.
	always_comb begin
		hit_frame = '0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			hit_frame = hit_frame | (match_vec[i] ? cell_frame[i] : '0);
		end
	end

	always_comb begin
		if (hit) begin
			res_frame = hit_frame;
		end else if (ram_present) begin
			res_frame = ram_frame;
		end else begin
			res_frame = alloc_frame;
		end
	end

	assign phys_ext = {{PA_W{1'b0}}, res_frame, offset_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			next_free_q <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PAGE_BITS'(PAGE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (hit) begin
						if (hit_cnt_q != '1) begin
							hit_cnt_q <= hit_cnt_q + 1'b1;
						end
					end else if (!ram_present) begin
						if (!frames_gone) begin
							next_free_q <= next_free_q + 1'b1;
						end
						if (fault_cnt_q != '1) begin
							fault_cnt_q <= fault_cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			va_q <= virtual_address;
		end
		if (lookup) begin
			phys_q  <= phys_ext[PA_W-1:0];
			hit_q   <= hit;
			fault_q <= !hit && !ram_present;
		end
	end

	assign done             = done_q;
	assign physical_address = phys_q;
	assign tlb_hit          = hit_q;
	assign page_fault       = fault_q;
	assign hit_total        = hit_cnt_q;
	assign fault_total      = fault_cnt_q;

	assign valid_plus = (TLB_ENTRIES + 1)'(valid_vec) + (TLB_ENTRIES + 1)'(1);

	`TLBL_ASSERT_ALWAYS(a_single_match, $onehot0(match_vec), "TLB holds a page twice")
	`TLBL_ASSERT_ALWAYS(a_valid_packed, $onehot(valid_plus), "TLB valid cells not packed at head")
	`TLBL_ASSERT_NEXT(a_accept_lookup, accept, state_q == ST_LOOKUP, "accepted item not looked up")
	`TLBL_ASSERT_IMPL(a_done_after_lookup, done, $past(state_q) == ST_LOOKUP, "result without lookup")
	`TLBL_ASSERT_IMPL(a_hit_no_fault, done, !(tlb_hit && page_fault), "TLB hit flagged as fault")

endmodule
